FILE: design/gba_pkg.sv
// gba_pkg: sizes, codes and payload types for the grouped bitmap allocator.
// Depends on nothing; used by grouped_bitmap_allocator.
package gba_pkg;

  localparam int NUM_GROUPS       = 4;
  localparam int BLOCKS_PER_GROUP = 8192;
  localparam int GROUP_INODES     = 2048;

  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int GIDX_W  = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GCNT_W  = $clog2(NUM_GROUPS + 1);
  localparam int B_WPG   = BLOCKS_PER_GROUP / WORD_W;
  localparam int I_WPG   = GROUP_INODES / WORD_W;
  localparam int B_WORDS = NUM_GROUPS * B_WPG;
  localparam int I_WORDS = NUM_GROUPS * I_WPG;
  localparam int B_AW    = $clog2(B_WORDS);
  localparam int I_AW    = $clog2(I_WORDS);
  localparam int WIG_W   = (B_WPG > 1) ? $clog2(B_WPG) : 1;
  localparam int BI_W    = $clog2(BLOCKS_PER_GROUP);
  localparam int B_TOTAL = NUM_GROUPS * BLOCKS_PER_GROUP;
  localparam int I_TOTAL = NUM_GROUPS * GROUP_INODES;

  // field widths fixed by the interface
  localparam int NUM_W   = 16;
  localparam int BTOT_W  = 16;
  localparam int ITOT_W  = 14;
  localparam int BPG_W   = 14;
  localparam int IPG_W   = 12;
  localparam int GRP_W   = 3;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 14;

  typedef enum logic [1:0] {
    CMD_ALLOC_BLOCK = 2'd0,
    CMD_ALLOC_INODE = 2'd1,
    CMD_FREE_BLOCK  = 2'd2,
    CMD_FREE_INODE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2
  } status_t;

  localparam logic [CFG_IW-1:0] REG_GROUPS = 3'd0;
  localparam logic [CFG_IW-1:0] REG_BPG    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_IPG    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_FDB    = 3'd3;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DIV, S_FRD, S_FWR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [NUM_W-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [NUM_W-1:0]  allocated;
    logic [1:0]        status;
    logic [BTOT_W-1:0] free_blocks_total;
    logic [ITOT_W-1:0] free_inodes_total;
  } out_item_t;

endpackage

FILE: design/grouped_bitmap_allocator.sv
// A valid free takes one subtract step per group crossed, then a read-modify-write of one
// bitmap word; an allocation reads one bitmap word after another and skips empty groups,
// up to a full scan of the 512-word block pool (one read port, one word a cycle).
// One command at a time; the next is taken once the result sits in the output register.
// Reset: synchronous; a clearing pass zeroes both bitmaps, input not ready.
// grouped_bitmap_allocator: top level, bitmaps in two word-wide RAMs. Uses gba_pkg.
module grouped_bitmap_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gba_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gba_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gba_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [gba_pkg::CFG_DW-1:0]     cfg_data
);

  localparam int W    = gba_pkg::WORD_W;
  localparam int GI   = gba_pkg::GIDX_W;
  localparam int GC   = gba_pkg::GCNT_W;
  localparam int WG   = gba_pkg::WIG_W;
  localparam int BAW  = gba_pkg::B_AW;
  localparam int IAW  = gba_pkg::I_AW;
  localparam int BIW  = gba_pkg::BI_W;
  localparam int PW   = gba_pkg::BPG_W;
  localparam int NW   = gba_pkg::NUM_W;
  localparam int BTW  = gba_pkg::BTOT_W;
  localparam int ITW  = gba_pkg::ITOT_W;
  localparam int IPW  = gba_pkg::IPG_W;
  localparam int GN   = gba_pkg::NUM_GROUPS;

  // configuration registers
  logic [gba_pkg::GRP_W-1:0] cfg_groups;
  logic [PW-1:0]             cfg_bpg;
  logic [IPW-1:0]            cfg_ipg;
  logic                      cfg_fdb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_groups <= gba_pkg::GRP_W'(GN);
      cfg_bpg    <= PW'(gba_pkg::BLOCKS_PER_GROUP);
      cfg_ipg    <= IPW'(gba_pkg::GROUP_INODES);
      cfg_fdb    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        gba_pkg::REG_GROUPS: cfg_groups <= cfg_data[gba_pkg::GRP_W-1:0];
        gba_pkg::REG_BPG:    cfg_bpg    <= cfg_data[PW-1:0];
        gba_pkg::REG_IPG:    cfg_ipg    <= cfg_data[IPW-1:0];
        gba_pkg::REG_FDB:    cfg_fdb    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [GC-1:0] groups;
  logic [PW-1:0] per_b, per_i;
  assign groups = (cfg_groups > gba_pkg::GRP_W'(GN)) ? GC'(GN) : GC'(cfg_groups);
  assign per_b  = (cfg_bpg > PW'(gba_pkg::BLOCKS_PER_GROUP)) ?
                  PW'(gba_pkg::BLOCKS_PER_GROUP) : cfg_bpg;
  assign per_i  = (cfg_ipg > IPW'(gba_pkg::GROUP_INODES)) ?
                  PW'(gba_pkg::GROUP_INODES) : PW'(cfg_ipg);

  // control and datapath registers
  gba_pkg::state_t state, state_next;
  logic           pool, pool_next;          // 0 block pool, 1 inode pool
  logic           is_free, is_free_next;
  logic           ok, ok_next;
  logic [GC-1:0]  ig, ig_next;              // scan issue group
  logic [WG-1:0]  iw, iw_next;              // scan issue word in group
  logic           pv, pv_next;              // read in flight
  logic [GI-1:0]  pg, pg_next;
  logic [WG-1:0]  pw, pw_next;
  logic [GI-1:0]  hg, hg_next;              // group of hit / freed bit
  logic [BIW-1:0] hi, hi_next;              // bit index within group
  logic [NW-1:0]  rem, rem_next;
  logic [GI-1:0]  dg, dg_next;
  logic [BAW-1:0] clr, clr_next;

  logic [PW-1:0]  gfree_b [GN];
  logic [IPW-1:0] gfree_i [GN];
  logic [BTW-1:0] tot_b;
  logic [ITW-1:0] tot_i;

  // bitmap RAMs
  logic [W-1:0]   bmem [gba_pkg::B_WORDS];
  logic [W-1:0]   imem [gba_pkg::I_WORDS];
  logic [W-1:0]   b_q, i_q, rd_q;
  logic           re, we;
  logic [GI-1:0]  rg, wg;
  logic [WG-1:0]  rw, ww;
  logic [W-1:0]   wdata;
  logic [BAW-1:0] b_ra, b_wa;
  logic [IAW-1:0] i_ra, i_wa;

  assign b_ra = BAW'(rg * gba_pkg::B_WPG + rw);
  assign i_ra = IAW'(rg * gba_pkg::I_WPG + rw);
  assign b_wa = (state == gba_pkg::S_CLEAR) ? clr : BAW'(wg * gba_pkg::B_WPG + ww);
  assign i_wa = (state == gba_pkg::S_CLEAR) ? clr[IAW-1:0] :
                IAW'(wg * gba_pkg::I_WPG + ww);

  always_ff @(posedge clk) begin
    if (re && !pool) b_q <= bmem[b_ra];
    if (re && pool)  i_q <= imem[i_ra];
    if (we && (!pool || state == gba_pkg::S_CLEAR)) bmem[b_wa] <= wdata;
    if (we && (pool  || state == gba_pkg::S_CLEAR)) imem[i_wa] <= wdata;
  end
  assign rd_q = pool ? i_q : b_q;

  // per-pool views
  logic [PW-1:0]  per;
  logic [WG-1:0]  last_w;
  logic [5:0]     last_b;
  logic           cur_nonzero;
  logic [PW-1:0]  per_m1;
  assign per     = pool ? per_i : per_b;
  assign per_m1  = per - PW'(1);
  assign last_w  = WG'(per_m1 >> gba_pkg::BIT_W);
  assign last_b  = per_m1[gba_pkg::BIT_W-1:0];
  assign cur_nonzero = pool ? (gfree_i[ig[GI-1:0]] != '0) : (gfree_b[ig[GI-1:0]] != '0);

  // first clear bit of the returned word, bits past the group end count as set
  logic [W-1:0] vmask, masked;
  logic [5:0]   zpos;
  logic         zhit;
  assign vmask  = (pw == last_w) ? ({W{1'b1}} >> (6'd63 - last_b)) : {W{1'b1}};
  assign masked = rd_q | ~vmask;
  assign zhit   = ~&masked;
  always_comb begin
    zpos = '0;
    for (int k = W - 1; k >= 0; k--) begin
      if (!masked[k]) zpos = 6'(k);
    end
  end

  // free request decode
  gba_pkg::cmd_t cmd;
  logic [NW-1:0] rel;
  logic          in_pool;
  assign cmd     = gba_pkg::cmd_t'(in_item.command);
  assign in_pool = in_item.command[0];
  assign rel     = in_pool ? (in_item.number - NW'(1)) : (in_item.number - NW'(cfg_fdb));

  logic          load_out;
  assign in_ready = (state == gba_pkg::S_IDLE);

  always_comb begin
    state_next   = state;
    pool_next    = pool;
    is_free_next = is_free;
    ok_next      = ok;
    ig_next      = ig;
    iw_next      = iw;
    pv_next      = 1'b0;
    pg_next      = pg;
    pw_next      = pw;
    hg_next      = hg;
    hi_next      = hi;
    rem_next     = rem;
    dg_next      = dg;
    clr_next     = clr;
    re = 1'b0; we = 1'b0;
    rg = ig[GI-1:0]; rw = iw;
    wg = pg; ww = pw;
    wdata    = '0;
    load_out = 1'b0;
    case (state)
      gba_pkg::S_CLEAR: begin
        we       = 1'b1;
        clr_next = clr + BAW'(1);
        if (clr == BAW'(gba_pkg::B_WORDS - 1)) state_next = gba_pkg::S_IDLE;
      end
      gba_pkg::S_IDLE: begin
        if (in_valid) begin
          pool_next    = in_pool;
          is_free_next = (cmd == gba_pkg::CMD_FREE_BLOCK) || (cmd == gba_pkg::CMD_FREE_INODE);
          ig_next      = '0;
          iw_next      = '0;
          rem_next     = rel;
          dg_next      = '0;
          ok_next      = 1'b0;
          if (groups == '0 || (in_pool ? per_i : per_b) == '0) begin
            state_next = gba_pkg::S_DONE;
          end else if (!in_item.command[1]) begin
            state_next = gba_pkg::S_SCAN;
          end else if (in_item.number == '0 || in_item.number < NW'(cfg_fdb) && !in_pool) begin
            state_next = gba_pkg::S_DONE;
          end else begin
            state_next = gba_pkg::S_DIV;
          end
        end
      end
      gba_pkg::S_SCAN: begin
        // issue side: one word a cycle, empty groups skipped
        if (ig < groups) begin
          if (!cur_nonzero) begin
            ig_next = ig + GC'(1);
            iw_next = '0;
          end else begin
            re      = 1'b1;
            pv_next = 1'b1;
            pg_next = ig[GI-1:0];
            pw_next = iw;
            if (iw == last_w) begin
              ig_next = ig + GC'(1);
              iw_next = '0;
            end else begin
              iw_next = iw + WG'(1);
            end
          end
        end
        // check side: word read in the previous cycle
        if (pv && zhit) begin
          we         = 1'b1;
          wdata      = rd_q | (W'(1) << zpos);
          hg_next    = pg;
          hi_next    = BIW'({pw, zpos});
          ok_next    = 1'b1;
          pv_next    = 1'b0;
          state_next = gba_pkg::S_DONE;
        end else if (!pv && !(ig < groups)) begin
          state_next = gba_pkg::S_DONE;
        end
      end
      gba_pkg::S_DIV: begin
        // rel / per by repeated subtraction, at most one step per group
        if (rem < NW'(per)) begin
          hg_next    = dg;
          hi_next    = rem[BIW-1:0];
          state_next = gba_pkg::S_FRD;
        end else if (GC'(dg) + GC'(1) >= groups) begin
          state_next = gba_pkg::S_DONE;
        end else begin
          rem_next = rem - NW'(per);
          dg_next  = dg + GI'(1);
        end
      end
      gba_pkg::S_FRD: begin
        re         = 1'b1;
        rg         = hg;
        rw         = WG'(hi >> gba_pkg::BIT_W);
        state_next = gba_pkg::S_FWR;
      end
      gba_pkg::S_FWR: begin
        we         = 1'b1;
        wg         = hg;
        ww         = WG'(hi >> gba_pkg::BIT_W);
        wdata      = rd_q & ~(W'(1) << hi[gba_pkg::BIT_W-1:0]);
        ok_next    = 1'b1;
        state_next = gba_pkg::S_DONE;
      end
      gba_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = gba_pkg::S_IDLE;
        end
      end
      default: state_next = gba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gba_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      pv  <= 1'b0;
    end else begin
      clr <= clr_next;
      pv  <= pv_next;
    end
    pool    <= pool_next;
    is_free <= is_free_next;
    ok      <= ok_next;
    ig      <= ig_next;
    iw      <= iw_next;
    pg      <= pg_next;
    pw      <= pw_next;
    hg      <= hg_next;
    hi      <= hi_next;
    rem     <= rem_next;
    dg      <= dg_next;
  end

  // count update and result
  logic [BTW-1:0] tot_b_next;
  logic [ITW-1:0] tot_i_next;
  logic [NW-1:0]  alloc_num;
  gba_pkg::status_t st;

  always_comb begin
    tot_b_next = tot_b;
    tot_i_next = tot_i;
    if (ok && !is_free) begin
      if (!pool && tot_b != '0) tot_b_next = tot_b - BTW'(1);
      if (pool  && tot_i != '0) tot_i_next = tot_i - ITW'(1);
    end else if (ok) begin
      if (!pool && tot_b < BTW'(gba_pkg::B_TOTAL)) tot_b_next = tot_b + BTW'(1);
      if (pool  && tot_i < ITW'(gba_pkg::I_TOTAL)) tot_i_next = tot_i + ITW'(1);
    end
    alloc_num = NW'(hg) * NW'(per) + NW'(hi) + (pool ? NW'(1) : NW'(cfg_fdb));
    if (ok)           st = gba_pkg::ST_DONE;
    else if (is_free) st = gba_pkg::ST_INVALID;
    else              st = gba_pkg::ST_EXHAUSTED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GN; g++) begin
        gfree_b[g] <= PW'(gba_pkg::BLOCKS_PER_GROUP);
        gfree_i[g] <= IPW'(gba_pkg::GROUP_INODES);
      end
      tot_b     <= BTW'(gba_pkg::B_TOTAL);
      tot_i     <= ITW'(gba_pkg::I_TOTAL);
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        tot_b <= tot_b_next;
        tot_i <= tot_i_next;
        if (ok && !is_free) begin
          if (pool) gfree_i[hg] <= gfree_i[hg] - IPW'(1);
          else      gfree_b[hg] <= gfree_b[hg] - PW'(1);
        end else if (ok) begin
          if (pool && gfree_i[hg] < IPW'(gba_pkg::GROUP_INODES))
            gfree_i[hg] <= gfree_i[hg] + IPW'(1);
          if (!pool && gfree_b[hg] < PW'(gba_pkg::BLOCKS_PER_GROUP))
            gfree_b[hg] <= gfree_b[hg] + PW'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load_out) begin
      out_item.allocated         <= (ok && !is_free) ? alloc_num : '0;
      out_item.status            <= st;
      out_item.free_blocks_total <= tot_b_next;
      out_item.free_inodes_total <= tot_i_next;
    end
  end

  // checks
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (rst)
    pv |-> state == gba_pkg::S_SCAN) else $error("read in flight outside scan");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second command taken");
  a_blk_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.free_blocks_total <= BTW'(gba_pkg::B_TOTAL))
    else $error("block total above pool size");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status != 2'd3) else $error("bad status code");

endmodule
